/* rtl/core/nsp_pkg.sv */
// Package for the note string parser: request and result types, parser state,
// mode codes and the shared length helper. Depends on nothing.
package nsp_pkg;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_OCT  = 3'd1;
    localparam logic [2:0] MODE_WID  = 3'd2;
    localparam logic [2:0] MODE_PAU  = 3'd3;
    localparam logic [2:0] MODE_NOTE = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_TWO   = 8'd50;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_G     = 8'd71;
    localparam logic [7:0] CH_SHARP = 8'd35;
    localparam logic [7:0] CH_O     = 8'd111;
    localparam logic [7:0] CH_W     = 8'd119;
    localparam logic [7:0] CH_P     = 8'd112;

    localparam logic [2:0] LET_B = 3'd1;
    localparam logic [2:0] LET_E = 3'd4;

    localparam logic [1:0] OCT_RESET = 2'd1;
    localparam logic [3:0] LEN_RESET = 4'd3;
    localparam logic [3:0] LEN_MAX   = 4'd12;

    localparam logic KIND_TONE = 1'b0;
    localparam logic KIND_REST = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } char_req_t;

    typedef struct packed {
        logic       event_kind;
        logic [1:0] octave_sel;
        logic [2:0] letter;
        logic       raised;
        logic [3:0] length;
    } note_req_t;

    typedef struct packed {
        logic [2:0] parse_mode;
        logic [2:0] held_letter;
        logic [1:0] cur_octave;
        logic [3:0] note_length;
    } parse_st_t;

    localparam parse_st_t ST_RESET = '{
        parse_mode:  MODE_IDLE,
        held_letter: 3'd0,
        cur_octave:  OCT_RESET,
        note_length: LEN_RESET
    };

    function automatic logic [3:0] arg_length(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = c - CH_ZERO;
            if (c > CH_ZERO && c <= CH_NINE)
                arg_length = d[3:0] + 4'd3;
            else
                arg_length = LEN_RESET;
        end
    endfunction

endpackage

/* rtl/core/nsp_step.sv */
// One parser step: current state and one character give the next state and
// at most one note code. Depends on nsp_pkg.
module nsp_step (
    input  nsp_pkg::parse_st_t st,
    input  nsp_pkg::char_req_t req,
    output nsp_pkg::parse_st_t st_next,
    output logic               emit,
    output nsp_pkg::note_req_t res
);
    import nsp_pkg::*;

    logic [7:0] c;
    logic       last;
    logic       sharp;
    logic       is_letter;
    logic [7:0] let_off;
    parse_st_t  st_tok;
    parse_st_t  st_work;

    assign c         = req.char_code;
    assign last      = req.final_char;
    assign sharp     = (c == CH_SHARP);
    assign is_letter = (c >= CH_A) && (c <= CH_G);
    assign let_off   = c - CH_A;

    // start a new token from this character
    always_comb
    begin
        st_tok = st;
        st_tok.parse_mode = MODE_IDLE;
        if (!last)
        begin
            if (c == CH_O)
                st_tok.parse_mode = MODE_OCT;
            else if (c == CH_W)
                st_tok.parse_mode = MODE_WID;
            else if (c == CH_P)
                st_tok.parse_mode = MODE_PAU;
            else if (is_letter)
            begin
                st_tok.parse_mode  = MODE_NOTE;
                st_tok.held_letter = let_off[2:0];
            end
        end
    end

    always_comb
    begin
        st_work = st;
        emit    = 1'b0;
        res     = '{event_kind: KIND_TONE, octave_sel: st.cur_octave, letter: 3'd0,
                    raised: 1'b0, length: st.note_length};
        unique case (st.parse_mode)
            MODE_OCT:
            begin
                if (c == CH_ONE || c == CH_TWO)
                    st_work.cur_octave = (c == CH_ONE) ? 2'd1 : 2'd2;
                st_work.parse_mode = MODE_IDLE;
            end
            MODE_WID:
            begin
                st_work.note_length = arg_length(c);
                st_work.parse_mode  = MODE_IDLE;
            end
            MODE_PAU:
            begin
                emit               = 1'b1;
                res.event_kind     = KIND_REST;
                res.length         = arg_length(c);
                st_work.parse_mode = MODE_IDLE;
            end
            MODE_NOTE:
            begin
                emit       = 1'b1;
                res.letter = st.held_letter;
                res.raised = sharp && (st.held_letter != LET_B)
                             && (st.held_letter != LET_E);
                if (sharp)
                    st_work.parse_mode = MODE_IDLE;
                else
                    st_work = st_tok;
            end
            default:
            begin
                st_work = st_tok;
            end
        endcase
        st_next = last ? ST_RESET : st_work;
    end

endmodule

/* rtl/core/note_string_parser.sv */
// Note string parser top level: request register, parser state, result register.
// Depends on nsp_pkg and nsp_step.
// A closing character enters the request register, its note code the result register.
// Throughput: one character per cycle unless the output stalls, set by the state update.
// Reset: asynchronous, active low; octave 1, length 3, nothing held, both stages empty.
// End of string: the state returns to its reset values after the final character.
module note_string_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  nsp_pkg::char_req_t char_req,
    output logic               note_valid,
    input  logic               note_stall,
    output nsp_pkg::note_req_t note_req
);
    import nsp_pkg::*;

    logic      in_valid_reg;
    char_req_t in_req_reg;
    parse_st_t st_reg;
    parse_st_t st_next;
    logic      note_valid_reg;
    note_req_t note_reg;
    logic      out_free;
    logic      adv;
    logic      emit;
    note_req_t res;

    assign out_free   = !note_valid_reg || !note_stall;
    assign adv        = in_valid_reg && out_free;
    assign char_stall = in_valid_reg && !out_free;
    assign note_valid = note_valid_reg;
    assign note_req   = note_reg;

    nsp_step u_step (
        .st      (st_reg),
        .req     (in_req_reg),
        .st_next (st_next),
        .emit    (emit),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            st_reg         <= ST_RESET;
            note_valid_reg <= 1'b0;
        end
        else
        begin
            if (!char_stall)
                in_valid_reg <= char_valid;
            if (adv)
                st_reg <= st_next;
            if (out_free)
                note_valid_reg <= adv && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
            in_req_reg <= char_req;
        if (adv && emit)
            note_reg <= res;
    end

`ifndef SYNTHESIS
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_req_reg.final_char |=> st_reg == ST_RESET)
        else $error("parser state not cleared after final character");

    a_no_sharp_be: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid && note_req.raised |->
            note_req.event_kind == KIND_TONE && note_req.letter != LET_B
            && note_req.letter != LET_E)
        else $error("sharp on B, E or a rest");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        note_valid |-> note_req.length >= LEN_RESET && note_req.length <= LEN_MAX
            && (note_req.octave_sel == 2'd1 || note_req.octave_sel == 2'd2))
        else $error("note code out of range");

    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |=> in_valid_reg && $stable(in_req_reg))
        else $error("request register changed while stalled");
`endif

endmodule

/* tb/note_string_parser_tb.sv */
// Testbench for note_string_parser: directed tune fragments, random tunes with stray bytes and
// byte noise, checked against an in-bench model of the parser. Depends on nsp_pkg and the RTL.
// The sender idles and the result side stalls at random; every note code is compared field by field.
module note_string_parser_tb;

    import nsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TUNE_GOAL   = 1420;
    localparam int NOISE_ITEMS = 330;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    char_req_t char_req = '0;
    logic      note_valid;
    logic      note_stall = 1'b0;
    note_req_t note_req;

    note_req_t notes_due[$];

    logic [2:0] tune_mode = MODE_IDLE;
    logic [2:0] tune_held = 3'd0;
    logic [1:0] tune_octave = OCT_RESET;
    logic [3:0] tune_length = LEN_RESET;

    int   burst_left = 0;
    bit   sender_calm = 1'b0;
    int   chars_sent = 0;
    int   tunes_sent = 0;
    int   notes_seen = 0;
    int   rests_seen = 0;
    int   sharps_seen = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    int         stall_span = 0;
    logic [1:0] stall_style = 2'd0;
    logic [3:0] stall_tick = 4'd0;

    note_string_parser DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_req   (char_req),
        .note_valid (note_valid),
        .note_stall (note_stall),
        .note_req   (note_req)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d note codes outstanding",
                     $realtime, cycle_count, notes_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style <= 2'($urandom_range(0, 3));
            stall_span  <= $urandom_range(50, 300);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        stall_tick <= stall_tick + 4'd1;
        case (stall_style)
            2'd0: note_stall <= 1'b0;
            2'd1: note_stall <= ($urandom_range(0, 3) == 0);
            2'd2: note_stall <= ($urandom_range(0, 3) != 0);
            default: note_stall <= (stall_tick >= 4'd11);
        endcase
    end

    always @(negedge clk)
    begin
        note_req_t want;
        if (rst_n && note_valid && !note_stall)
        begin
            if (notes_due.size() == 0)
            begin
                $display("%0t: unexpected note code, expected none actual %p",
                         $realtime, note_req);
                mismatches++;
            end
            else
            begin
                want = notes_due.pop_front();
                notes_seen++;
                if (want.event_kind == KIND_REST)
                    rests_seen++;
                if (want.raised)
                    sharps_seen++;
                if (note_req.event_kind !== want.event_kind)
                begin
                    $display("%0t: event_kind expected %0d actual %0d",
                             $realtime, want.event_kind, note_req.event_kind);
                    mismatches++;
                end
                if (note_req.octave_sel !== want.octave_sel)
                begin
                    $display("%0t: octave_sel expected %0d actual %0d",
                             $realtime, want.octave_sel, note_req.octave_sel);
                    mismatches++;
                end
                if (note_req.letter !== want.letter)
                begin
                    $display("%0t: letter expected %0d actual %0d",
                             $realtime, want.letter, note_req.letter);
                    mismatches++;
                end
                if (note_req.raised !== want.raised)
                begin
                    $display("%0t: raised expected %0d actual %0d",
                             $realtime, want.raised, note_req.raised);
                    mismatches++;
                end
                if (note_req.length !== want.length)
                begin
                    $display("%0t: length expected %0d actual %0d",
                             $realtime, want.length, note_req.length);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [3:0] digit_length(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = c - CH_ZERO;
            if (c >= CH_ONE && c <= CH_NINE)
                return d[3:0] + 4'd3;
            return LEN_RESET;
        end
    endfunction

    task automatic open_token(input logic [7:0] c, input logic last);
        logic [7:0] d;
        begin
            d = c - CH_A;
            tune_mode = MODE_IDLE;
            if (!last)
            begin
                if (c == CH_O)
                    tune_mode = MODE_OCT;
                else if (c == CH_W)
                    tune_mode = MODE_WID;
                else if (c == CH_P)
                    tune_mode = MODE_PAU;
                else if (c >= CH_A && c <= CH_G)
                begin
                    tune_held = d[2:0];
                    tune_mode = MODE_NOTE;
                end
            end
        end
    endtask

    task automatic advance_parser(input logic [7:0] c, input logic last);
        note_req_t n;
        logic      hash;
        begin
            hash = (c == CH_SHARP);
            case (tune_mode)
                MODE_OCT:
                begin
                    if (c == CH_ONE || c == CH_TWO)
                        tune_octave = c[1:0];
                    tune_mode = MODE_IDLE;
                end
                MODE_WID:
                begin
                    tune_length = digit_length(c);
                    tune_mode = MODE_IDLE;
                end
                MODE_PAU:
                begin
                    n = '{event_kind: KIND_REST, octave_sel: tune_octave, letter: 3'd0,
                          raised: 1'b0, length: digit_length(c)};
                    notes_due.push_back(n);
                    tune_mode = MODE_IDLE;
                end
                MODE_NOTE:
                begin
                    n = '{event_kind: KIND_TONE, octave_sel: tune_octave, letter: tune_held,
                          raised: hash && tune_held != LET_B && tune_held != LET_E,
                          length: tune_length};
                    notes_due.push_back(n);
                    if (hash)
                        tune_mode = MODE_IDLE;
                    else
                        open_token(c, last);
                end
                default: open_token(c, last);
            endcase
            if (last)
            begin
                tune_mode   = MODE_IDLE;
                tune_held   = 3'd0;
                tune_octave = OCT_RESET;
                tune_length = LEN_RESET;
            end
        end
    endtask

    task automatic send_char(input logic [7:0] code, input logic last);
        int   gap;
        logic took;
        begin
            if (burst_left == 0)
            begin
                gap = sender_calm ? 0 : $urandom_range(0, 6);
                if (gap != 0)
                begin
                    char_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            char_req   <= '{char_code: code, final_char: last};
            char_valid <= 1'b1;
            do
            begin
                @(negedge clk);
                took = !char_stall;
                @(posedge clk);
            end
            while (!took);
            advance_parser(code, last);
            chars_sent++;
        end
    endtask

    function automatic logic [7:0] random_arg(input int lo, input int hi);
        begin
            if ($urandom_range(0, 4) != 0)
                return 8'(CH_ZERO + $urandom_range(lo, hi));
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic test_directed();
        begin
            send_char(CH_O, 1'b0);
            send_char(CH_TWO, 1'b0);
            send_char("C", 1'b0);
            send_char(CH_SHARP, 1'b0);
            send_char(CH_W, 1'b0);
            send_char(CH_NINE, 1'b0);
            send_char("B", 1'b0);
            send_char(CH_SHARP, 1'b0);
            send_char("E", 1'b0);
            send_char("D", 1'b0);
            send_char(CH_P, 1'b0);
            send_char(CH_ONE, 1'b0);
            send_char(CH_W, 1'b0);
            send_char(CH_ZERO, 1'b0);
            send_char(CH_O, 1'b0);
            send_char("x", 1'b0);
            send_char(CH_O, 1'b0);
            send_char(CH_ONE, 1'b0);
            send_char(CH_G, 1'b0);
            send_char(8'h00, 1'b0);
            send_char(8'hFF, 1'b0);
            send_char(CH_SHARP, 1'b0);
            send_char(CH_P, 1'b0);
            send_char(CH_NINE, 1'b1);
            send_char(CH_A, 1'b1);
            send_char(CH_A, 1'b0);
            send_char(CH_W, 1'b1);
            tunes_sent += 3;
        end
    endtask

    task automatic test_random_tunes(input int goal);
        logic [7:0] tune[$];
        int         tokens;
        begin
            while (chars_sent < goal)
            begin
                tune.delete();
                tokens = $urandom_range(1, 8);
                repeat (tokens)
                begin
                    case ($urandom_range(0, 9))
                        0, 1:
                        begin
                            tune.push_back(CH_O);
                            tune.push_back(random_arg(1, 2));
                        end
                        2:
                        begin
                            tune.push_back(CH_W);
                            tune.push_back(random_arg(0, 9));
                        end
                        3:
                        begin
                            tune.push_back(CH_P);
                            tune.push_back(random_arg(0, 9));
                        end
                        4, 5, 6, 7:
                        begin
                            tune.push_back(8'(CH_A + $urandom_range(0, 6)));
                            if ($urandom_range(0, 2) == 0)
                                tune.push_back(CH_SHARP);
                        end
                        8: tune.push_back(8'($urandom_range(0, 255)));
                        default: tune.push_back(CH_SHARP);
                    endcase
                end
                sender_calm = ($urandom_range(0, 3) == 0);
                foreach (tune[i])
                    send_char(tune[i], i == tune.size() - 1);
                tunes_sent++;
            end
            sender_calm = 1'b0;
        end
    endtask

    task automatic test_noise(input int count);
        begin
            repeat (count)
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            send_char(CH_ZERO, 1'b1);
        end
    endtask

    task automatic drain_notes();
        begin
            char_valid <= 1'b0;
            while (notes_due.size() != 0)
                @(posedge clk);
            repeat (6) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_tunes(TUNE_GOAL);
        test_noise(NOISE_ITEMS);
        drain_notes();
        $display("Covered %0d characters over about %0d tunes plus byte noise.",
                 chars_sent, tunes_sent);
        $display("Checked %0d note codes: %0d rests, %0d sharp tones, %0d mismatches.",
                 notes_seen, rests_seen, sharps_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/nsp_pkg.sv
rtl/core/nsp_step.sv
rtl/core/note_string_parser.sv
tb/note_string_parser_tb.sv
